>>> src/wmfa_pkg.sv
// wmfa_pkg: opcodes and fixed field widths of the width masked fold alu
// no dependencies
`default_nettype none

package wmfa_pkg;

  localparam int unsigned MODE_W  = 5;
  localparam int unsigned WIDTH_W = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_EQ    = 5'd0,
    MODE_NE    = 5'd1,
    MODE_SLT   = 5'd2,
    MODE_SLE   = 5'd3,
    MODE_ULT   = 5'd4,
    MODE_ULE   = 5'd5,
    MODE_AND   = 5'd6,
    MODE_XOR   = 5'd7,
    MODE_OR    = 5'd8,
    MODE_ADD   = 5'd9,
    MODE_SUB   = 5'd10,
    MODE_MUL   = 5'd11,
    MODE_UDIV  = 5'd12,
    MODE_SDIV  = 5'd13,
    MODE_SHL   = 5'd14,
    MODE_SHR   = 5'd15,
    MODE_SEXT  = 5'd16,
    MODE_ZEXT  = 5'd17,
    MODE_TRUNC = 5'd18
  } mode_e;

endpackage

`default_nettype wire

>>> src/wmfa_req_if.sv
// wmfa_req_if: request channel with valid/ready and operand payload
// depends on wmfa_pkg
`default_nettype none

interface wmfa_req_if #(
  parameter int unsigned DATA_WIDTH = 64
);
  logic                              valid;
  logic                              ready;
  logic [wmfa_pkg::MODE_W-1:0]       mode;
  logic [DATA_WIDTH-1:0]             a_value;
  logic [DATA_WIDTH-1:0]             b_value;
  logic [wmfa_pkg::WIDTH_W-1:0]      op_width;
  logic [wmfa_pkg::WIDTH_W-1:0]      src_width;
  logic                              no_unsigned_wrap;
  logic                              no_signed_wrap;

  modport source (
    output valid, mode, a_value, b_value, op_width, src_width,
           no_unsigned_wrap, no_signed_wrap,
    input  ready
  );
  modport sink (
    input  valid, mode, a_value, b_value, op_width, src_width,
           no_unsigned_wrap, no_signed_wrap,
    output ready
  );
endinterface

`default_nettype wire

>>> src/wmfa_rsp_if.sv
// wmfa_rsp_if: result channel with valid/ready, folded value and poison
// no dependencies
`default_nettype none

interface wmfa_rsp_if #(
  parameter int unsigned DATA_WIDTH = 64
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] folded_value;
  logic                  poison;

  modport source (output valid, folded_value, poison, input ready);
  modport sink   (input  valid, folded_value, poison, output ready);
endinterface

`default_nettype wire

>>> src/wmfa_mul.sv
// wmfa_mul: registered split multiplier, unsigned and signed full products
// partial products of at most half width plus one are registered, then summed
`default_nettype none

module wmfa_mul #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [DATA_WIDTH-1:0]     a_i,
  input  wire logic [DATA_WIDTH-1:0]     b_i,
  input  wire logic [DATA_WIDTH-1:0]     sa_i,
  input  wire logic [DATA_WIDTH-1:0]     sb_i,
  output logic      [2*DATA_WIDTH-1:0]   prod_u_o,
  output logic      [2*DATA_WIDTH-1:0]   prod_s_o
);
  localparam int unsigned LW = DATA_WIDTH / 2;
  localparam int unsigned HW = DATA_WIDTH - LW;
  localparam int unsigned PW = 2 * DATA_WIDTH;

  // unsigned partial products
  logic [2*LW-1:0]     ull_q;
  logic [LW+HW-1:0]    ulh_q, uhl_q;
  logic [2*HW-1:0]     uhh_q;
  // signed partial products, low halves unsigned
  logic [2*LW-1:0]          sll_q;
  logic signed [LW+HW:0]    slh_q, shl_q;
  logic signed [2*HW-1:0]   shh_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ull_q <= a_i[LW-1:0] * b_i[LW-1:0];
      ulh_q <= a_i[LW-1:0] * b_i[DATA_WIDTH-1:LW];
      uhl_q <= a_i[DATA_WIDTH-1:LW] * b_i[LW-1:0];
      uhh_q <= a_i[DATA_WIDTH-1:LW] * b_i[DATA_WIDTH-1:LW];
      sll_q <= sa_i[LW-1:0] * sb_i[LW-1:0];
      slh_q <= $signed({1'b0, sa_i[LW-1:0]}) * $signed(sb_i[DATA_WIDTH-1:LW]);
      shl_q <= $signed(sa_i[DATA_WIDTH-1:LW]) * $signed({1'b0, sb_i[LW-1:0]});
      shh_q <= $signed(sa_i[DATA_WIDTH-1:LW]) * $signed(sb_i[DATA_WIDTH-1:LW]);
    end
  end

  logic signed [PW-1:0] slh_x, shl_x, shh_x;
  assign slh_x = slh_q;
  assign shl_x = shl_q;
  assign shh_x = shh_q;

  assign prod_u_o = PW'(ull_q) + (PW'(ulh_q) << LW) + (PW'(uhl_q) << LW)
                  + (PW'(uhh_q) << (2 * LW));
  assign prod_s_o = PW'(sll_q) + (PW'(slh_x) << LW) + (PW'(shl_x) << LW)
                  + (PW'(shh_x) << (2 * LW));

endmodule

`default_nettype wire

>>> src/wmfa_div_cell.sv
// wmfa_div_cell: one restoring divide step, one quotient bit per cell
// carries the side payload of its request to the next cell
`default_nettype none

module wmfa_div_cell #(
  parameter int unsigned DATA_WIDTH = 64,
  parameter int unsigned PAY_WIDTH  = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic [DATA_WIDTH-1:0] rem_i,
  input  wire logic [DATA_WIDTH-1:0] nq_i,
  input  wire logic [DATA_WIDTH-1:0] dvs_i,
  input  wire logic [PAY_WIDTH-1:0]  pay_i,
  output logic                       valid_o,
  output logic      [DATA_WIDTH-1:0] rem_o,
  output logic      [DATA_WIDTH-1:0] nq_o,
  output logic      [DATA_WIDTH-1:0] dvs_o,
  output logic      [PAY_WIDTH-1:0]  pay_o
);
  logic [DATA_WIDTH:0]   part;
  logic [DATA_WIDTH:0]   trial;
  logic                  qbit;
  logic [DATA_WIDTH-1:0] rem_d, nq_d;

  always_comb begin
    part  = {rem_i, nq_i[DATA_WIDTH-1]};
    trial = part - {1'b0, dvs_i};
    qbit  = !trial[DATA_WIDTH];
    rem_d = qbit ? trial[DATA_WIDTH-1:0] : part[DATA_WIDTH-1:0];
    nq_d  = {nq_i[DATA_WIDTH-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      nq_o  <= nq_d;
      dvs_o <= dvs_i;
      pay_o <= pay_i;
    end
  end

endmodule

`default_nettype wire

>>> src/width_masked_integer_fold_alu.sv
// width_masked_integer_fold_alu: variable width integer fold alu with poison
// depends on wmfa_pkg, wmfa_req_if, wmfa_rsp_if, wmfa_mul, wmfa_div_cell
//
// usage
//   req_i carries one request per valid/ready handshake: opcode, two operands,
//   operating width, source width and the two no-wrap flags. rsp_o returns
//   one result per request, in request order: the value masked to the width
//   and a poison flag (set on guarded overflow or division by zero, value 0)
//   a request passes the stage a, b and c registers, the divider row and the
//   output register; the divider is a row of DATA_WIDTH cells, one quotient
//   bit each; throughput: one request per cycle while the pipe is not frozen
//   the whole pipe moves together; it freezes only while a result sits in
//   the output register and the receiver holds ready low, so req_i.ready
//   follows rsp_o.ready whenever the output register is full
//   reset clears every stage valid, no result is pending afterwards
`default_nettype none

module width_masked_integer_fold_alu #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  wmfa_req_if.sink   req_i,
  wmfa_rsp_if.source rsp_o
);
  localparam int unsigned WW  = $clog2(DATA_WIDTH + 1);
  localparam int unsigned PW  = 2 * DATA_WIDTH;
  localparam int unsigned PAY = 2 * DATA_WIDTH + 3;

  // mask of the low w bits
  function automatic logic [DATA_WIDTH-1:0] wmask(input logic [WW-1:0] w);
    wmask = {DATA_WIDTH{1'b1}} >> (WW'(DATA_WIDTH) - w);
  endfunction

  // value at w bits, sign extended to the full width
  function automatic logic [DATA_WIDTH-1:0] sext(input logic [DATA_WIDTH-1:0] x,
                                                 input logic [WW-1:0] w);
    logic [DATA_WIDTH-1:0] m;
    m    = DATA_WIDTH'(1) << (w - WW'(1));
    sext = ((x & wmask(w)) ^ m) - m;
  endfunction

  // clamp a width field into 1 .. DATA_WIDTH
  function automatic logic [WW-1:0] clampw(input logic [wmfa_pkg::WIDTH_W-1:0] w);
    if (w == '0) begin
      clampw = WW'(1);
    end else if (w > wmfa_pkg::WIDTH_W'(DATA_WIDTH)) begin
      clampw = WW'(DATA_WIDTH);
    end else begin
      clampw = w[WW-1:0];
    end
  endfunction

  // whole pipe advances unless the output register is held
  logic en;
  assign en          = !rsp_o.valid || rsp_o.ready;
  assign req_i.ready = en;

  // ---------------- stage a: capture request, clamp widths
  logic                  va_q;
  wmfa_pkg::mode_e       mode_a_q;
  logic [DATA_WIDTH-1:0] a_raw_a_q, b_raw_a_q;
  logic [WW-1:0]         w_a_q, s_a_q;
  logic                  nuw_a_q, nsw_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode_a_q  <= wmfa_pkg::mode_e'(req_i.mode);
      a_raw_a_q <= req_i.a_value;
      b_raw_a_q <= req_i.b_value;
      w_a_q     <= clampw(req_i.op_width);
      s_a_q     <= clampw(req_i.src_width);
      nuw_a_q   <= req_i.no_unsigned_wrap;
      nsw_a_q   <= req_i.no_signed_wrap;
    end
  end

  // ---------------- stage b: mask operands, fold everything but mul and div
  logic [DATA_WIDTH-1:0] mask_b, a_b, b_b, sa_b, sb_b, r_b, dvd_b, dvs_b;
  logic [DATA_WIDTH:0]   sum_b;
  logic                  poison_b, div_b, neg_b, big_shift_b;
  logic [WW-1:0]         zw_b;

  always_comb begin
    mask_b      = wmask(w_a_q);
    a_b         = a_raw_a_q & mask_b;
    b_b         = b_raw_a_q & mask_b;
    sa_b        = sext(a_b, w_a_q);
    sb_b        = sext(b_b, w_a_q);
    sum_b       = {1'b0, a_b} + {1'b0, b_b};
    big_shift_b = b_raw_a_q >= DATA_WIDTH'(w_a_q);
    zw_b        = (s_a_q < w_a_q) ? s_a_q : w_a_q;
    r_b         = '0;
    poison_b    = 1'b0;
    div_b       = 1'b0;
    neg_b       = 1'b0;
    dvd_b       = '0;
    dvs_b       = '0;
    case (mode_a_q)
      wmfa_pkg::MODE_EQ:  r_b = DATA_WIDTH'(a_b == b_b);
      wmfa_pkg::MODE_NE:  r_b = DATA_WIDTH'(a_b != b_b);
      wmfa_pkg::MODE_SLT: r_b = DATA_WIDTH'($signed(sa_b) < $signed(sb_b));
      wmfa_pkg::MODE_SLE: r_b = DATA_WIDTH'($signed(sa_b) <= $signed(sb_b));
      wmfa_pkg::MODE_ULT: r_b = DATA_WIDTH'(a_b < b_b);
      wmfa_pkg::MODE_ULE: r_b = DATA_WIDTH'(a_b <= b_b);
      wmfa_pkg::MODE_AND: r_b = a_b & b_b;
      wmfa_pkg::MODE_XOR: r_b = a_b ^ b_b;
      wmfa_pkg::MODE_OR:  r_b = a_b | b_b;
      wmfa_pkg::MODE_ADD: begin
        r_b      = sum_b[DATA_WIDTH-1:0] & mask_b;
        // carry out of the operating width
        poison_b = nuw_a_q && (sum_b[DATA_WIDTH] ||
                               ((sum_b[DATA_WIDTH-1:0] & ~mask_b) != '0));
      end
      wmfa_pkg::MODE_SUB: begin
        r_b      = (a_b - b_b) & mask_b;
        poison_b = nuw_a_q && (a_b < b_b);
      end
      wmfa_pkg::MODE_MUL: r_b = '0; // folded in stage c
      wmfa_pkg::MODE_UDIV: begin
        poison_b = (b_b == '0);
        div_b    = 1'b1;
        dvd_b    = a_b;
        dvs_b    = b_b;
      end
      wmfa_pkg::MODE_SDIV: begin
        // divide magnitudes, fix the sign after the cell row
        poison_b = (b_b == '0);
        div_b    = 1'b1;
        neg_b    = sa_b[DATA_WIDTH-1] ^ sb_b[DATA_WIDTH-1];
        dvd_b    = sa_b[DATA_WIDTH-1] ? -sa_b : sa_b;
        dvs_b    = sb_b[DATA_WIDTH-1] ? -sb_b : sb_b;
      end
      wmfa_pkg::MODE_SHL:
        r_b = big_shift_b ? '0 : ((a_b << b_raw_a_q[WW-1:0]) & mask_b);
      wmfa_pkg::MODE_SHR:
        r_b = big_shift_b ? '0 : (a_b >> b_raw_a_q[WW-1:0]);
      wmfa_pkg::MODE_SEXT:  r_b = sext(a_raw_a_q, s_a_q) & mask_b;
      wmfa_pkg::MODE_ZEXT:  r_b = a_raw_a_q & wmask(zw_b);
      wmfa_pkg::MODE_TRUNC: r_b = a_raw_a_q & mask_b;
      default:              r_b = '0;
    endcase
  end

  logic                  vb_q, poison_b_q, div_b_q, neg_b_q, nuw_b_q, nsw_b_q, mul_b_q;
  logic [DATA_WIDTH-1:0] r_b_q, mask_b_q, dvd_b_q, dvs_b_q;
  logic [WW-1:0]         w_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_b_q      <= r_b;
      poison_b_q <= poison_b;
      div_b_q    <= div_b;
      neg_b_q    <= neg_b;
      dvd_b_q    <= dvd_b;
      dvs_b_q    <= dvs_b;
      mask_b_q   <= mask_b;
      w_b_q      <= w_a_q;
      nuw_b_q    <= nuw_a_q;
      nsw_b_q    <= nsw_a_q;
      mul_b_q    <= (mode_a_q == wmfa_pkg::MODE_MUL);
    end
  end

  // partial products registered alongside stage b
  logic [PW-1:0] prod_u, prod_s;

  wmfa_mul #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_mul (
    .clk_i    (clk_i),
    .en_i     (en),
    .a_i      (a_b),
    .b_i      (b_b),
    .sa_i     (sa_b),
    .sb_i     (sb_b),
    .prod_u_o (prod_u),
    .prod_s_o (prod_s)
  );

  // ---------------- stage c: finish mul, overflow checks
  logic [DATA_WIDTH-1:0] slo_c, r_c;
  logic                  uovf_c, sovf_c, poison_c;

  always_comb begin
    slo_c    = prod_s[DATA_WIDTH-1:0];
    // unsigned: anything at or above bit w
    uovf_c   = (prod_u[PW-1:DATA_WIDTH] != '0) ||
               ((prod_u[DATA_WIDTH-1:0] & ~mask_b_q) != '0);
    // signed: full product must be a w bit two's complement value
    sovf_c   = (sext(slo_c, w_b_q) != slo_c) ||
               (prod_s[PW-1:DATA_WIDTH] != {DATA_WIDTH{slo_c[DATA_WIDTH-1]}});
    r_c      = r_b_q;
    poison_c = poison_b_q;
    if (mul_b_q) begin
      r_c      = prod_u[DATA_WIDTH-1:0] & mask_b_q;
      poison_c = (nuw_b_q && uovf_c) || (nsw_b_q && sovf_c);
    end
  end

  logic                  vc_q, poison_c_q, div_c_q, neg_c_q;
  logic [DATA_WIDTH-1:0] r_c_q, mask_c_q, dvd_c_q, dvs_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_c_q      <= r_c;
      poison_c_q <= poison_c;
      div_c_q    <= div_b_q;
      neg_c_q    <= neg_b_q;
      mask_c_q   <= mask_b_q;
      dvd_c_q    <= dvd_b_q;
      dvs_c_q    <= dvs_b_q;
    end
  end

  // ---------------- divider cell row, side payload travels along
  logic                  ch_v   [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] ch_rem [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] ch_nq  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] ch_dvs [0:DATA_WIDTH];
  logic [PAY-1:0]        ch_pay [0:DATA_WIDTH];

  assign ch_v[0]   = vc_q;
  assign ch_rem[0] = '0;
  assign ch_nq[0]  = dvd_c_q;
  assign ch_dvs[0] = dvs_c_q;
  assign ch_pay[0] = {r_c_q, mask_c_q, poison_c_q, div_c_q, neg_c_q};

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    wmfa_div_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .PAY_WIDTH  (PAY)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (ch_v[i]),
      .rem_i   (ch_rem[i]),
      .nq_i    (ch_nq[i]),
      .dvs_i   (ch_dvs[i]),
      .pay_i   (ch_pay[i]),
      .valid_o (ch_v[i+1]),
      .rem_o   (ch_rem[i+1]),
      .nq_o    (ch_nq[i+1]),
      .dvs_o   (ch_dvs[i+1]),
      .pay_o   (ch_pay[i+1])
    );
  end

  // ---------------- output stage: quotient sign, select, poison
  logic [DATA_WIDTH-1:0] e_r, e_mask, e_q, e_val;
  logic                  e_poison, e_div, e_neg;

  always_comb begin
    {e_r, e_mask, e_poison, e_div, e_neg} = ch_pay[DATA_WIDTH];
    e_q   = e_neg ? -ch_nq[DATA_WIDTH] : ch_nq[DATA_WIDTH];
    e_val = e_div ? (e_q & e_mask) : e_r;
    if (e_poison) begin
      e_val = '0;
    end
  end

  logic                  out_v_q, out_p_q;
  logic [DATA_WIDTH-1:0] out_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= ch_v[DATA_WIDTH];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_r_q <= e_val;
      out_p_q <= e_poison;
    end
  end

  assign rsp_o.valid        = out_v_q;
  assign rsp_o.folded_value = out_r_q;
  assign rsp_o.poison       = out_p_q;

  // ---------------- checks
  a_poison_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.poison |-> rsp_o.folded_value == '0)
    else $error("poisoned result carries a nonzero value");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.ready |=> rsp_o.valid && $stable(rsp_o.folded_value))
    else $error("held result changed under stall");

  a_neg_only_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q && !div_c_q |-> !neg_c_q)
    else $error("quotient negate flagged on a non divide request");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(ch_v[DATA_WIDTH]) && $stable(vc_q))
    else $error("pipe moved while the output was held");

endmodule

`default_nettype wire

>>> dv/width_masked_integer_fold_alu_test.sv
// width_masked_integer_fold_alu_test: self-checking bench for the width masked fold alu
// drives requests through wmfa_req_if, checks results on wmfa_rsp_if against an inline predictor
// depends on wmfa_pkg, wmfa_req_if, wmfa_rsp_if and width_masked_integer_fold_alu
`default_nettype none

module width_masked_integer_fold_alu_test;

  localparam int unsigned MODE_W    = wmfa_pkg::MODE_W;
  localparam int unsigned WIDTH_W   = wmfa_pkg::WIDTH_W;
  localparam int unsigned DW        = 64;
  localparam int unsigned LATENCY   = DW + 3;
  localparam int unsigned N_RANDOM  = 500;
  localparam int unsigned LIMIT     = 200000;
  localparam int unsigned HOLD_LEN  = 300;
  localparam int unsigned HOLD_AT   = 150;

  // one request as queued for the driver, with its own idle gap
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [DW-1:0]      a_value;
    logic [DW-1:0]      b_value;
    logic [WIDTH_W-1:0] op_width;
    logic [WIDTH_W-1:0] src_width;
    logic               nuw;
    logic               nsw;
    logic [2:0]         gap;
  } fold_req_t;

  typedef struct packed {
    logic [DW-1:0] value;
    logic          poison;
  } fold_rsp_t;

  logic clk;
  logic rst_n;

  wmfa_req_if #(.DATA_WIDTH(DW)) req_if ();
  wmfa_rsp_if #(.DATA_WIDTH(DW)) rsp_if ();

  width_masked_integer_fold_alu #(.DATA_WIDTH(DW)) u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  fold_req_t pending_reqs[$];
  fold_rsp_t expected_folds[$];

  int unsigned issued_cnt;
  int unsigned accepted_cnt;
  int unsigned result_cnt;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;

  // clock, period 20
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // widths of 0 act as 1, anything above the data width saturates
  function automatic int unsigned clamp_w(logic [WIDTH_W-1:0] w);
    if (w == 0) return 1;
    if (w > DW) return DW;
    return 32'(w);
  endfunction

  function automatic logic [DW-1:0] low_mask(int unsigned w);
    return {DW{1'b1}} >> (DW - w);
  endfunction

  function automatic logic [DW-1:0] sign_ext(logic [DW-1:0] x, int unsigned w);
    logic [DW-1:0] m;
    m = {{(DW-1){1'b0}}, 1'b1} << (w - 1);
    return ((x & low_mask(w)) ^ m) - m;
  endfunction

  function automatic fold_rsp_t fold_expect(fold_req_t r);
    int unsigned     w;
    int unsigned     s;
    logic [DW-1:0]   mask;
    logic [DW-1:0]   a;
    logic [DW-1:0]   b;
    logic [DW-1:0]   sa;
    logic [DW-1:0]   sb;
    logic [DW-1:0]   ma;
    logic [DW-1:0]   mb;
    logic [DW-1:0]   q;
    logic [2*DW-1:0] uprod;
    logic [2*DW-1:0] sprod;
    logic [2*DW-1:0] m2;
    logic [2*DW-1:0] sfit;
    fold_rsp_t       res;
    w    = clamp_w(r.op_width);
    s    = clamp_w(r.src_width);
    mask = low_mask(w);
    a    = r.a_value & mask;
    b    = r.b_value & mask;
    sa   = sign_ext(a, w);
    sb   = sign_ext(b, w);
    res  = '0;
    case (r.mode)
      wmfa_pkg::MODE_EQ:  res.value = DW'(a == b);
      wmfa_pkg::MODE_NE:  res.value = DW'(a != b);
      wmfa_pkg::MODE_SLT: res.value = DW'($signed(sa) < $signed(sb));
      wmfa_pkg::MODE_SLE: res.value = DW'($signed(sa) <= $signed(sb));
      wmfa_pkg::MODE_ULT: res.value = DW'(a < b);
      wmfa_pkg::MODE_ULE: res.value = DW'(a <= b);
      wmfa_pkg::MODE_AND: res.value = a & b;
      wmfa_pkg::MODE_XOR: res.value = a ^ b;
      wmfa_pkg::MODE_OR:  res.value = a | b;
      wmfa_pkg::MODE_ADD: begin
        // sum at full width plus carry, then masked
        uprod = {{DW{1'b0}}, a} + {{DW{1'b0}}, b};
        res.value = uprod[DW-1:0] & mask;
        if (r.nuw && ((uprod >> w) != 0)) res.poison = 1'b1;
      end
      wmfa_pkg::MODE_SUB: begin
        res.value = (a - b) & mask;
        if (r.nuw && a < b) res.poison = 1'b1;
      end
      wmfa_pkg::MODE_MUL: begin
        // unsigned overflow: any product bit at or above w
        uprod = {{DW{1'b0}}, a} * {{DW{1'b0}}, b};
        // signed overflow: product does not fit w bits two's complement
        sprod = {{DW{sa[DW-1]}}, sa} * {{DW{sb[DW-1]}}, sb};
        m2    = {{(2*DW-1){1'b0}}, 1'b1} << (w - 1);
        sfit  = (((sprod & {{DW{1'b0}}, mask})) ^ m2) - m2;
        if (r.nuw && ((uprod >> w) != 0)) res.poison = 1'b1;
        else if (r.nsw && sfit != sprod) res.poison = 1'b1;
        else res.value = uprod[DW-1:0] & mask;
      end
      wmfa_pkg::MODE_UDIV: begin
        if (b == 0) res.poison = 1'b1;
        else res.value = (a / b) & mask;
      end
      wmfa_pkg::MODE_SDIV: begin
        // divide magnitudes, truncate toward zero, most negative / -1 wraps
        if (b == 0) begin
          res.poison = 1'b1;
        end else begin
          ma = sa[DW-1] ? -sa : sa;
          mb = sb[DW-1] ? -sb : sb;
          q  = ma / mb;
          if (sa[DW-1] != sb[DW-1]) q = -q;
          res.value = q & mask;
        end
      end
      // shift amount is the raw unmasked operand
      wmfa_pkg::MODE_SHL:
        res.value = (r.b_value >= w) ? '0 : ((a << r.b_value) & mask);
      wmfa_pkg::MODE_SHR:
        res.value = (r.b_value >= w) ? '0 : (a >> r.b_value);
      wmfa_pkg::MODE_SEXT:  res.value = sign_ext(r.a_value, s) & mask;
      wmfa_pkg::MODE_ZEXT:  res.value = r.a_value & low_mask((s < w) ? s : w);
      wmfa_pkg::MODE_TRUNC: res.value = r.a_value & mask;
      default:              res.value = '0;
    endcase
    if (res.poison) res.value = '0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [DW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // operand biased toward edges of the operating width
  function automatic logic [DW-1:0] pick_operand(int unsigned w);
    logic [DW-1:0] m;
    m = low_mask(w);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return m;
      2: return m >> 1;
      3: return (m >> 1) + 1;
      4: return DW'($urandom_range(0, 3));
      5: return rand64() >> $urandom_range(0, DW - 1);
      default: return rand64();
    endcase
  endfunction

  function automatic logic [WIDTH_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0: return 1;
      1: return 8;
      2: return 32;
      3: return 63;
      4: return 64;
      5: return WIDTH_W'($urandom_range(0, 127));
      default: return WIDTH_W'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic queue_req(logic [MODE_W-1:0] mode, logic [DW-1:0] a, logic [DW-1:0] b,
                           logic [WIDTH_W-1:0] w, logic [WIDTH_W-1:0] s,
                           logic nuw, logic nsw, logic [2:0] gap);
    fold_req_t r;
    r.mode      = mode;
    r.a_value   = a;
    r.b_value   = b;
    r.op_width  = w;
    r.src_width = s;
    r.nuw       = nuw;
    r.nsw       = nsw;
    r.gap       = gap;
    pending_reqs.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: changes inputs on the falling edge
  // ---------------------------------------------------------------------------
  int unsigned gap_left;

  always @(negedge clk) begin
    fold_req_t nxt;
    logic      consumed;
    if (rst_n) begin
      // the request on the bus is gone once the accept counter caught up
      consumed = !req_if.valid || (accepted_cnt == issued_cnt);
      if (consumed) begin
        if (gap_left > 0 || pending_reqs.size() == 0) begin
          if (gap_left > 0) gap_left <= gap_left - 1;
          req_if.valid <= 1'b0;
        end else begin
          nxt = pending_reqs.pop_front();
          req_if.valid            <= 1'b1;
          req_if.mode             <= nxt.mode;
          req_if.a_value          <= nxt.a_value;
          req_if.b_value          <= nxt.b_value;
          req_if.op_width         <= nxt.op_width;
          req_if.src_width        <= nxt.src_width;
          req_if.no_unsigned_wrap <= nxt.nuw;
          req_if.no_signed_wrap   <= nxt.nsw;
          issued_cnt              <= issued_cnt + 1;
          gap_left                <= pending_reqs.size() == 0 ? 0 : pending_reqs[0].gap;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result ready: random stalls, one long hold-off to back up the pipe
  // ---------------------------------------------------------------------------
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned seen_results;
  logic        hold_done;

  always @(negedge clk) begin
    int unsigned draw;
    if (rst_n) begin
      if (!hold_done && accepted_cnt >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN;
        rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else if (seen_results != result_cnt) begin
        // a result went through: draw the wait before the next one,
        // none in a middle stretch so the output runs at full rate
        seen_results <= result_cnt;
        if (result_cnt > 250 && result_cnt < 350) begin
          stall_left   <= 0;
          rsp_if.ready <= 1'b1;
        end else begin
          draw         = $urandom_range(0, 5);
          stall_left   <= (draw > 0) ? draw - 1 : 0;
          rsp_if.ready <= (draw == 0);
        end
      end else if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: samples both channels on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    fold_req_t acc;
    fold_rsp_t exp_r;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT) begin
      $display("width_masked_integer_fold_alu regression: fail");
      $finish;
    end
    if (rst_n && req_if.valid && req_if.ready) begin
      acc.mode      = req_if.mode;
      acc.a_value   = req_if.a_value;
      acc.b_value   = req_if.b_value;
      acc.op_width  = req_if.op_width;
      acc.src_width = req_if.src_width;
      acc.nuw       = req_if.no_unsigned_wrap;
      acc.nsw       = req_if.no_signed_wrap;
      acc.gap       = '0;
      expected_folds.push_back(fold_expect(acc));
      accepted_cnt <= accepted_cnt + 1;
    end
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      result_cnt <= result_cnt + 1;
      if (expected_folds.size() == 0) begin
        mismatch_cnt = mismatch_cnt + 1;
        if (mismatch_cnt <= 10)
          $display("unexpected result: value=%h poison=%b",
                   rsp_if.folded_value, rsp_if.poison);
      end else begin
        exp_r = expected_folds.pop_front();
        if (rsp_if.folded_value !== exp_r.value || rsp_if.poison !== exp_r.poison) begin
          mismatch_cnt = mismatch_cnt + 1;
          if (mismatch_cnt <= 10)
            $display("result %0d mismatch: value exp=%h got=%h poison exp=%b got=%b",
                     result_cnt, exp_r.value, rsp_if.folded_value,
                     exp_r.poison, rsp_if.poison);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: reset, directed requests, random requests, drain
  // ---------------------------------------------------------------------------
  initial begin
    logic [WIDTH_W-1:0] w;
    logic [DW-1:0]      m;
    logic [MODE_W-1:0]  md;
    rst_n                   = 1'b0;
    req_if.valid            = 1'b0;
    req_if.mode             = '0;
    req_if.a_value          = '0;
    req_if.b_value          = '0;
    req_if.op_width         = '0;
    req_if.src_width        = '0;
    req_if.no_unsigned_wrap = 1'b0;
    req_if.no_signed_wrap   = 1'b0;
    rsp_if.ready            = 1'b0;
    issued_cnt   = 0;
    accepted_cnt = 0;
    result_cnt   = 0;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    gap_left     = 0;
    stall_left   = 0;
    hold_left    = 0;
    seen_results = 0;
    hold_done    = 1'b0;

    // directed: every even opcode, including unused ones, full width
    for (int i = 0; i < 32; i += 2) begin
      md = MODE_W'(i);
      queue_req(md, rand64(), rand64(), 64, 16, 1'b1, 1'b1, 0);
    end
    // unsigned add wrap under the flag, 8 bits
    queue_req(wmfa_pkg::MODE_ADD, 64'hff, 64'h01, 8, 8, 1'b1, 1'b0, 1);
    // signed mul overflow at 8 bits, and its no-flag counterpart
    queue_req(wmfa_pkg::MODE_MUL, 64'h40, 64'h02, 8, 8, 1'b0, 1'b1, 0);
    queue_req(wmfa_pkg::MODE_MUL, 64'h40, 64'h02, 8, 8, 1'b0, 1'b0, 0);
    // division by zero, both flavors
    queue_req(wmfa_pkg::MODE_UDIV, '1, '0, 64, 64, 1'b0, 1'b0, 2);
    queue_req(wmfa_pkg::MODE_SDIV, 5, 64'h100, 8, 8, 1'b0, 1'b0, 0);
    // most negative over minus one wraps
    queue_req(wmfa_pkg::MODE_SDIV, 64'h8000_0000_0000_0000, '1, 64, 64, 1'b0, 1'b0, 0);
    queue_req(wmfa_pkg::MODE_SDIV, 64'h80, 64'hff, 8, 8, 1'b0, 1'b0, 0);
    // shifts past the width, and with a huge unmasked amount
    queue_req(wmfa_pkg::MODE_SHL, '1, 64, 64, 64, 1'b0, 1'b0, 0);
    queue_req(wmfa_pkg::MODE_SHR, '1, 64'h1_0000_0001, 32, 32, 1'b0, 1'b0, 0);
    // widths out of range: zero and above the data width
    queue_req(wmfa_pkg::MODE_SEXT, '1, '0, 0, 0, 1'b0, 1'b0, 0);
    queue_req(wmfa_pkg::MODE_ZEXT, '1, '1, 127, 127, 1'b0, 1'b0, 3);
    // sign extend with source wider than destination, zext narrower source
    queue_req(wmfa_pkg::MODE_SEXT, 64'h80, '0, 4, 8, 1'b0, 1'b0, 0);
    queue_req(wmfa_pkg::MODE_ZEXT, '1, '0, 40, 12, 1'b0, 1'b0, 0);

    // random: mostly defined opcodes, a few unused ones
    for (int i = 0; i < N_RANDOM; i++) begin
      w  = pick_width();
      md = ($urandom_range(0, 19) == 0) ? MODE_W'($urandom_range(19, 31))
                                        : MODE_W'($urandom_range(0, 18));
      if ((md == wmfa_pkg::MODE_SHL || md == wmfa_pkg::MODE_SHR) &&
          $urandom_range(0, 3) != 0)
        m = DW'($urandom_range(0, 70));
      else
        m = pick_operand(clamp_w(w));
      queue_req(md, pick_operand(clamp_w(w)), m, w, pick_width(),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                (i > 200 && i < 300) ? 3'd0 : 3'($urandom_range(0, 5)));
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_reqs.size() == 0 && accepted_cnt == issued_cnt && expected_folds.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    mismatch_cnt = mismatch_cnt + expected_folds.size();
    if (mismatch_cnt == 0) begin
      $display("width_masked_integer_fold_alu regression: pass");
    end else begin
      $display("width_masked_integer_fold_alu regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
